// ===== design/djpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// djpm_pkg: shared definitions for the dijet pairing block
// Widths, reset values, register indexes, sequencer states and split tables.
// ----------------------------------------------------------------------------
package djpm_pkg;

  localparam int VALUE_WIDTH_DEF = 22;
  localparam int CFG_WIDTH       = 21;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_WIDTH-1:0] W_TARGET_RST = 21'd5145;
  localparam logic [CFG_WIDTH-1:0] Z_TARGET_RST = 21'd5836;
  localparam logic [CFG_WIDTH-1:0] WW_LOW_RST   = 21'd3840;
  localparam logic [CFG_WIDTH-1:0] WW_HIGH_RST  = 21'd5632;
  localparam logic [CFG_WIDTH-1:0] ZZ_LOW_RST   = 21'd5440;
  localparam logic [CFG_WIDTH-1:0] ZZ_HIGH_RST  = 21'd6400;

  typedef enum logic [2:0] {
    REG_W_TARGET = 3'd0,
    REG_Z_TARGET = 3'd1,
    REG_WW_LOW   = 3'd2,
    REG_WW_HIGH  = 3'd3,
    REG_ZZ_LOW   = 3'd4,
    REG_ZZ_HIGH  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] w_target;
    logic [CFG_WIDTH-1:0] z_target;
    logic [CFG_WIDTH-1:0] ww_low;
    logic [CFG_WIDTH-1:0] ww_high;
    logic [CFG_WIDTH-1:0] zz_low;
    logic [CFG_WIDTH-1:0] zz_high;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADD,
    ST_SQ,
    ST_DIFF,
    ST_SQRT,
    ST_ROUND,
    ST_METRIC,
    ST_UPDATE,
    ST_EMIT
  } back_state_t;

  // Split 0 is 01|23, split 1 is 02|13, split 2 is 03|12.
  function automatic logic [1:0] pair_first(input logic [1:0] split, input logic pair);
    logic [1:0] idx;
    idx = 2'd0;
    if (pair) begin
      case (split)
        2'd0:    idx = 2'd2;
        2'd1:    idx = 2'd1;
        default: idx = 2'd1;
      endcase
    end
    return idx;
  endfunction

  function automatic logic [1:0] pair_second(input logic [1:0] split, input logic pair);
    logic [1:0] idx;
    idx = 2'd3;
    if (!pair) begin
      case (split)
        2'd0:    idx = 2'd1;
        2'd1:    idx = 2'd2;
        default: idx = 2'd3;
      endcase
    end else begin
      case (split)
        2'd0:    idx = 2'd3;
        2'd1:    idx = 2'd3;
        default: idx = 2'd2;
      endcase
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== design/djpm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// djpm_front: particle collector
// Stores the first three particles of an event and pushes the whole event
// into the queue when the fourth arrives.
// ----------------------------------------------------------------------------
module djpm_front import djpm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int PW = 4 * VALUE_WIDTH - 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [PW-1:0] in_particle,
  input  logic          q_full,
  output logic          q_push,
  output logic [4*PW-1:0] q_data
);

  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic [PW-1:0] stored_r [3];
  logic          accept;

  assign in_ready = (cnt_r != 2'd3) || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (cnt_r == 2'd3);
  assign q_data   = {in_particle, stored_r[2], stored_r[1], stored_r[0]};
  assign cnt_nxt  = cnt_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (cnt_r != 2'd3)) begin
      stored_r[cnt_r] <= in_particle;
    end
  end

endmodule
`default_nettype wire

// ===== design/djpm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// djpm_queue: event queue
// A short first-in first-out buffer of complete events between the collector
// and the pairing sequencer.
// ----------------------------------------------------------------------------
module djpm_queue import djpm_pkg::*; #(
  parameter int DATA_W = 8,
  localparam int PTR_W = $clog2(QUEUE_DEPTH),
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] head
);

  logic [DATA_W-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_r;
  logic [PTR_W-1:0]  rd_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = entry_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/djpm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// djpm_back: pairing sequencer
// Forms pair sums, squares them on one shared multiplier, takes a bit-serial
// rounded square root, scores the three splits and holds the result.
// ----------------------------------------------------------------------------
module djpm_back import djpm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int VW   = VALUE_WIDTH,
  localparam int MW   = VW - 1,
  localparam int PW   = 4 * VW - 1,
  localparam int OW   = 6 * MW + 8,
  localparam int SW   = VW + 1,
  localparam int SQW  = 2 * VW + 2,
  localparam int RADW = 2 * VW,
  localparam int DW   = (MW > CFG_WIDTH) ? MW : CFG_WIDTH,
  localparam int OPW  = (SW > DW) ? SW : DW,
  localparam int PRW  = 2 * OPW,
  localparam int MTW  = 2 * DW + 1,
  localparam int ITW  = $clog2(VW)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          q_valid,
  input  logic [4*PW-1:0] q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [OW-1:0] out_data
);

  back_state_t state_r, state_nxt;

  logic [PW-1:0]     part_r [4];
  logic [1:0]        split_r;
  logic              pair_r;
  logic [2:0]        sub_r;
  logic [ITW-1:0]    it_r;
  logic signed [SW-1:0] sx_r, sy_r, sz_r;
  logic [VW-1:0]     se_r;
  logic [PRW-1:0]    prod_r;
  logic [SQW-1:0]    e2_r, p2_r;
  logic [RADW-1:0]   rem_r, bit_r;
  logic [RADW:0]     res_r;
  logic [MW-1:0]     m_r [2];
  logic [MTW-1:0]    mw_r, mz_r;
  logic [1:0]        bw_idx_r, bz_idx_r, bb_idx_r;
  logic [MTW-1:0]    bw_met_r, bz_met_r;
  logic [MW-1:0]     bb_met_r;
  logic [MW-1:0]     bw_hi_r, bw_lo_r, bz_hi_r, bz_lo_r, bb_hi_r, bb_lo_r;
  logic              out_valid_r;
  logic [OW-1:0]     out_data_r;

  logic              out_free;
  logic              out_load;
  logic [1:0]        rd_sel;
  logic [PW-1:0]     rd_part;
  logic signed [SW-1:0] ex, ey, ez;
  logic [VW-1:0]     ee;
  logic [OPW-1:0]    mul_op;
  logic [PRW-1:0]    prod;
  logic [RADW:0]     trial;
  logic [VW:0]       rnd;
  logic [MW-1:0]     mass;
  logic [DW-1:0]     dw1, dw2, dz1, dz2;
  logic [MW-1:0]     hi, lo, bal;
  logic              is_ww, is_zz;

  function automatic logic [DW-1:0] adiff(input logic [DW-1:0] a, input logic [DW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [OPW-1:0] mag(input logic signed [SW-1:0] v);
    logic [SW-1:0] u;
    u = v[SW-1] ? SW'(-v) : SW'(v);
    return OPW'(u);
  endfunction

  function automatic logic inwin(input logic [MW-1:0] v, input logic [CFG_WIDTH-1:0] low,
                                 input logic [CFG_WIDTH-1:0] high);
    return (DW'(low) < DW'(v)) && (DW'(v) < DW'(high));
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign rd_part  = part_r[rd_sel];
  assign ex   = SW'(signed'(rd_part[VW-1:0]));
  assign ey   = SW'(signed'(rd_part[2*VW-1:VW]));
  assign ez   = SW'(signed'(rd_part[3*VW-1:2*VW]));
  assign ee   = VW'(rd_part[PW-1:3*VW]);
  assign prod = mul_op * mul_op;
  assign trial = res_r + (RADW + 1)'(bit_r);
  assign rnd  = res_r[VW:0] + (VW + 1)'(({1'b0, rem_r} > res_r) ? 1 : 0);
  assign mass = (|rnd[VW:MW]) ? '1 : rnd[MW-1:0];
  assign dw1  = adiff(DW'(m_r[0]), DW'(cfg.w_target));
  assign dw2  = adiff(DW'(m_r[1]), DW'(cfg.w_target));
  assign dz1  = adiff(DW'(m_r[0]), DW'(cfg.z_target));
  assign dz2  = adiff(DW'(m_r[1]), DW'(cfg.z_target));
  assign hi   = (m_r[0] > m_r[1]) ? m_r[0] : m_r[1];
  assign lo   = (m_r[0] > m_r[1]) ? m_r[1] : m_r[0];
  assign bal  = hi - lo;
  assign is_ww = inwin(bw_hi_r, cfg.ww_low, cfg.ww_high) && inwin(bw_lo_r, cfg.ww_low, cfg.ww_high);
  assign is_zz = inwin(bz_hi_r, cfg.zz_low, cfg.zz_high) && inwin(bz_lo_r, cfg.zz_low, cfg.zz_high);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (q_valid) state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_ADD;
      ST_ADD:    state_nxt = ST_SQ;
      ST_SQ:     if (sub_r == 3'd4) state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_SQRT;
      ST_SQRT:   if (it_r == ITW'(VW - 1)) state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = pair_r ? ST_METRIC : ST_LOAD;
      ST_METRIC: if (sub_r == 3'd4) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = (split_r == 2'd2) ? ST_EMIT : ST_LOAD;
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    rd_sel   = pair_first(split_r, pair_r);
    mul_op   = '0;
    case (state_r)
      ST_IDLE: q_pop = q_valid;
      ST_ADD:  rd_sel = pair_second(split_r, pair_r);
      ST_SQ: begin
        case (sub_r)
          3'd0:    mul_op = OPW'(se_r);
          3'd1:    mul_op = mag(sx_r);
          3'd2:    mul_op = mag(sy_r);
          3'd3:    mul_op = mag(sz_r);
          default: mul_op = '0;
        endcase
      end
      ST_METRIC: begin
        case (sub_r)
          3'd0:    mul_op = OPW'(dw1);
          3'd1:    mul_op = OPW'(dw2);
          3'd2:    mul_op = OPW'(dz1);
          3'd3:    mul_op = OPW'(dz2);
          default: mul_op = '0;
        endcase
      end
      ST_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      split_r     <= 2'd0;
      pair_r      <= 1'b0;
      sub_r       <= 3'd0;
      it_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          split_r <= 2'd0;
          pair_r  <= 1'b0;
        end
        ST_ADD:    sub_r <= 3'd0;
        ST_SQ:     sub_r <= sub_r + 3'd1;
        ST_DIFF:   it_r <= '0;
        ST_SQRT:   it_r <= it_r + ITW'(1);
        ST_ROUND: begin
          pair_r <= ~pair_r;
          sub_r  <= 3'd0;
        end
        ST_METRIC: sub_r <= sub_r + 3'd1;
        ST_UPDATE: split_r <= split_r + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    case (state_r)
      ST_IDLE: begin
        for (int i = 0; i < 4; i++) begin
          part_r[i] <= q_data[i*PW +: PW];
        end
      end
      ST_LOAD: begin
        sx_r <= ex;
        sy_r <= ey;
        sz_r <= ez;
        se_r <= ee;
      end
      ST_ADD: begin
        sx_r <= sx_r + ex;
        sy_r <= sy_r + ey;
        sz_r <= sz_r + ez;
        se_r <= se_r + ee;
      end
      ST_SQ: begin
        case (sub_r)
          3'd1:    e2_r <= prod_r[SQW-1:0];
          3'd2:    p2_r <= prod_r[SQW-1:0];
          3'd3:    p2_r <= p2_r + prod_r[SQW-1:0];
          3'd4:    p2_r <= p2_r + prod_r[SQW-1:0];
          default: ;
        endcase
      end
      ST_DIFF: begin
        rem_r <= (e2_r > p2_r) ? RADW'(e2_r - p2_r) : '0;
        res_r <= '0;
        bit_r <= RADW'(1) << (RADW - 2);
      end
      ST_SQRT: begin
        if ({1'b0, rem_r} >= trial) begin
          rem_r <= rem_r - trial[RADW-1:0];
          res_r <= (res_r >> 1) + (RADW + 1)'(bit_r);
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_ROUND: m_r[pair_r] <= mass;
      ST_METRIC: begin
        case (sub_r)
          3'd1:    mw_r <= MTW'(prod_r[2*DW-1:0]);
          3'd2:    mw_r <= mw_r + MTW'(prod_r[2*DW-1:0]);
          3'd3:    mz_r <= MTW'(prod_r[2*DW-1:0]);
          3'd4:    mz_r <= mz_r + MTW'(prod_r[2*DW-1:0]);
          default: ;
        endcase
      end
      ST_UPDATE: begin
        if ((split_r == 2'd0) || (mw_r < bw_met_r)) begin
          bw_met_r <= mw_r;
          bw_idx_r <= split_r;
          bw_hi_r  <= hi;
          bw_lo_r  <= lo;
        end
        if ((split_r == 2'd0) || (mz_r < bz_met_r)) begin
          bz_met_r <= mz_r;
          bz_idx_r <= split_r;
          bz_hi_r  <= hi;
          bz_lo_r  <= lo;
        end
        if ((split_r == 2'd0) || (bal < bb_met_r)) begin
          bb_met_r <= bal;
          bb_idx_r <= split_r;
          bb_hi_r  <= hi;
          bb_lo_r  <= lo;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= {is_zz, is_ww, bb_lo_r, bb_hi_r, bb_idx_r, bz_lo_r, bz_hi_r, bz_idx_r,
                     bw_lo_r, bw_hi_r, bw_idx_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_emit_split: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (bw_idx_r != 2'd3) && (bz_idx_r != 2'd3) && (bb_idx_r != 2'd3))
    else $error("chosen split index out of range");
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result raised outside emit");
  a_round_after_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> ($past(state_r) == ST_SQRT) && ($past(it_r) == ITW'(VW - 1)))
    else $error("rounding without a full root");
`endif

endmodule
`default_nettype wire

// ===== design/dijet_pairing_by_mass.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dijet_pairing_by_mass: four-particle pairing by invariant mass
// Collects four particles per event and reports the splits closest to the
// W mass, the Z mass and to equal masses, with WW and ZZ window flags.
// ----------------------------------------------------------------------------
// Particles are accepted one per cycle, but an event's fourth particle waits
// while the event queue is full; every fourth transaction closes an event,
// which goes into a two-entry event queue. The pairing sequencer's time per
// event is set by the single shared squaring multiplier and the square root
// unit that resolves one result bit per cycle for each of the six pair masses.
// The result waits in an output register while the next event is processed.
// ----------------------------------------------------------------------------
module dijet_pairing_by_mass import djpm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int MW = VALUE_WIDTH - 1,
  localparam int PW = 4 * VALUE_WIDTH - 1,
  localparam int OW = 6 * MW + 8,
  localparam int IN_TDATA_W = ((PW + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((OW + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // mom_x, mom_y, mom_z, energy
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // w_split, w_mass_high, w_mass_low, z_split, z_mass_high, z_mass_low,
  // balanced_split, balanced_mass_high, balanced_mass_low, is_ww, is_zz
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t             cfg_r;
  logic             cfg_wr;
  logic [CFG_WIDTH-1:0] wval;
  logic [CFG_WIDTH-1:0] rval;
  logic             q_full, q_push, q_pop, q_valid;
  logic [4*PW-1:0]  q_in, q_head;
  logic [OW-1:0]    out_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign wval       = cfg_pwdata[CFG_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.w_target <= W_TARGET_RST;
      cfg_r.z_target <= Z_TARGET_RST;
      cfg_r.ww_low   <= WW_LOW_RST;
      cfg_r.ww_high  <= WW_HIGH_RST;
      cfg_r.zz_low   <= ZZ_LOW_RST;
      cfg_r.zz_high  <= ZZ_HIGH_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_W_TARGET: cfg_r.w_target <= wval;
        REG_Z_TARGET: cfg_r.z_target <= wval;
        REG_WW_LOW:   cfg_r.ww_low   <= wval;
        REG_WW_HIGH:  cfg_r.ww_high  <= wval;
        REG_ZZ_LOW:   cfg_r.zz_low   <= wval;
        REG_ZZ_HIGH:  cfg_r.zz_high  <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_W_TARGET: rval = cfg_r.w_target;
      REG_Z_TARGET: rval = cfg_r.z_target;
      REG_WW_LOW:   rval = cfg_r.ww_low;
      REG_WW_HIGH:  rval = cfg_r.ww_high;
      REG_ZZ_LOW:   rval = cfg_r.zz_low;
      REG_ZZ_HIGH:  rval = cfg_r.zz_high;
      default:      rval = '0;
    endcase
  end

  assign cfg_prdata = CFG_DATA_W'(rval);

  djpm_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_particle (in_tdata[PW-1:0]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  djpm_queue #(.DATA_W(4 * PW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  djpm_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tdata = OUT_TDATA_W'(out_data);

endmodule
`default_nettype wire
